[design/spha_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// spha_pkg
// Shared sizes, register indexes, reset values, types and helper functions
// for the spectrum peak-hold and frame-averaging block.
// ============================================================================

package spha_pkg;

    // Storage limits.
    localparam int MAX_BINS       = 4096;
    localparam int MAX_AVG_FRAMES = 16;

    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int SLOT_W     = $clog2(MAX_AVG_FRAMES);
    localparam int HIST_AW    = SLOT_W + BIN_W;
    localparam int HIST_DEPTH = MAX_BINS * MAX_AVG_FRAMES;
    localparam int NB_W       = BIN_W + 1;
    localparam int NA_W       = SLOT_W + 1;

    // Data widths.
    localparam int DB_W        = 16;
    localparam int SUM_W       = DB_W + SLOT_W;
    localparam int BIN_WORD_W  = SUM_W + DB_W;
    localparam int RECIP_W     = 24;
    localparam int QPROD_W     = SUM_W + RECIP_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AVG_FRAMES  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DB    = CFG_IDX_W'(4);

    typedef logic signed [DB_W-1:0]  db_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    // Reset values of the configuration registers.
    localparam logic [NB_W-1:0] NUM_BINS_RST   = NB_W'(1024);
    localparam logic [NA_W-1:0] AVG_FRAMES_RST = NA_W'(1);
    localparam logic            HOLD_RST       = 1'b0;
    localparam logic [15:0]     DECAY_RST      = 16'd62259;
    localparam db_t             FLOOR_RST      = -16'sd2080;

    // Running-sum update modes.
    localparam logic [1:0] SUM_FIRST = 2'd0;
    localparam logic [1:0] SUM_ADD   = 2'd1;
    localparam logic [1:0] SUM_SLIDE = 2'd2;

    // Control for the peak update.
    typedef struct packed {
        logic hold_on;
        logic primed;
    } peak_ctl_t;

    // Bin count clamped to 1..MAX_BINS.
    function automatic logic [NB_W-1:0] eff_bins(input logic [NB_W-1:0] r);
        logic [NB_W-1:0] v;
        if (r == '0)
            v = NB_W'(1);
        else if (r > NB_W'(MAX_BINS))
            v = NB_W'(MAX_BINS);
        else
            v = r;
        return v;
    endfunction

    // Averaging depth clamped to 1..MAX_AVG_FRAMES.
    function automatic logic [NA_W-1:0] eff_avg(input logic [NA_W-1:0] r);
        logic [NA_W-1:0] v;
        if (r == '0)
            v = NA_W'(1);
        else if (r > NA_W'(MAX_AVG_FRAMES))
            v = NA_W'(MAX_AVG_FRAMES);
        else
            v = r;
        return v;
    endfunction

    // ceil(2^24 / n). A 20-bit magnitude times this, shifted right by 24,
    // is the exact truncated quotient for every divisor from 2 to 16.
    function automatic logic [RECIP_W-1:0] recip(input logic [NA_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            NA_W'(2):  r = RECIP_W'(8388608);
            NA_W'(3):  r = RECIP_W'(5592406);
            NA_W'(4):  r = RECIP_W'(4194304);
            NA_W'(5):  r = RECIP_W'(3355444);
            NA_W'(6):  r = RECIP_W'(2796203);
            NA_W'(7):  r = RECIP_W'(2396746);
            NA_W'(8):  r = RECIP_W'(2097152);
            NA_W'(9):  r = RECIP_W'(1864136);
            NA_W'(10): r = RECIP_W'(1677722);
            NA_W'(11): r = RECIP_W'(1525202);
            NA_W'(12): r = RECIP_W'(1398102);
            NA_W'(13): r = RECIP_W'(1290556);
            NA_W'(14): r = RECIP_W'(1198373);
            NA_W'(15): r = RECIP_W'(1118482);
            NA_W'(16): r = RECIP_W'(1048576);
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

[design/spha_peak_calc.sv]
`timescale 1ns / 1ps
// ============================================================================
// spha_peak_calc
// Decays a held peak toward the floor and takes the maximum with a new bin.
// ============================================================================

module spha_peak_calc (
    input  spha_pkg::peak_ctl_t ctl,
    input  spha_pkg::db_t       old_peak,
    input  spha_pkg::db_t       sample,
    input  spha_pkg::db_t       floor_lvl,
    input  logic [15:0]         decay,
    output spha_pkg::db_t       store_peak,
    output spha_pkg::db_t       peak_out
);
    import spha_pkg::*;

    logic signed [DB_W:0]     diff;
    logic signed [2*DB_W+1:0] prod;
    logic signed [DB_W:0]     decayed_wide;
    db_t                      decayed;
    db_t                      held;

    // floor + (peak - floor) * d / 65536, rounded toward minus infinity.
    assign diff         = {old_peak[DB_W-1], old_peak} - {floor_lvl[DB_W-1], floor_lvl};
    assign prod         = diff * $signed({1'b0, decay});
    assign decayed_wide = {floor_lvl[DB_W-1], floor_lvl} + $signed(prod[2*DB_W:DB_W]);
    assign decayed      = decayed_wide[DB_W-1:0];

    assign held = !ctl.primed ? sample : ((sample > decayed) ? sample : decayed);

    assign store_peak = ctl.hold_on ? held : old_peak;
    assign peak_out   = ctl.hold_on ? held : '0;

endmodule

[design/spectrum_peak_hold_averager.sv]
`timescale 1ns / 1ps
// ============================================================================
// spectrum_peak_hold_averager
// Per-bin frame averaging and decaying peak hold for a streamed spectrum.
// ============================================================================
//
// The block takes one spectrum bin per clock while in_ready is high and returns
// one result word per bin: the bin averaged over the last avg_frames frames
// (the raw bin until that many frames are held), the decayed peak for the bin,
// and a flag on the last bin of a frame. It sustains one word per clock while
// the output side is not stalled. That rate is set by the per-bin
// read-modify-write of the two memories: each is read once at acceptance and
// written once as the word leaves stage 1, and a one-entry forwarding register
// covers a bin that is read while its previous update is still being written.
// The per-bin peak and running sum share one 4096-entry memory, and the
// averaging history lives in a 65536-entry memory; neither is cleared after
// reset, so there is no start-up pass. Configuration registers are to be
// written only while the block is idle; the block itself does not enforce it.

module spectrum_peak_hold_averager (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  spha_pkg::db_t                      bin_db,

    output logic                               out_valid,
    input  logic                               out_ready,
    output spha_pkg::db_t                      display_db,
    output spha_pkg::db_t                      peak_db,
    output logic                               peak_valid,
    output logic                               frame_end,

    input  logic                               cfg_write,
    input  logic [spha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [spha_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spha_pkg::*;

    // Control carried with a word from acceptance into the memory stage.
    typedef struct packed {
        db_t                sample;
        logic [BIN_W-1:0]   bin;
        logic [HIST_AW-1:0] hist_addr;
        logic               hold_on;
        logic               primed;
        logic               avg_on;
        logic [1:0]         sum_mode;
        logic               div_on;
        logic [NA_W-1:0]    na;
        logic               last;
    } s1_t;

    // Word after the memory update, ahead of the divider.
    typedef struct packed {
        sum_t               sum;
        db_t                sample;
        db_t                peak;
        logic               hold_on;
        logic               div_on;
        logic [NA_W-1:0]    na;
        logic               last;
    } s2_t;

    // Word after the reciprocal multiply.
    typedef struct packed {
        logic [QPROD_W-1:0] prod;
        logic               neg;
        db_t                sample;
        db_t                peak;
        logic               hold_on;
        logic               div_on;
        logic               last;
    } s3_t;

    // ------------------------------------------------------------------
    // Configuration and frame bookkeeping
    // ------------------------------------------------------------------
    logic [NB_W-1:0]   num_bins_reg;
    logic [NA_W-1:0]   avg_frames_reg;
    logic              hold_en_reg;
    logic [15:0]       decay_reg;
    db_t               floor_reg;

    logic [BIN_W-1:0]  bin_cnt_reg;
    logic [NA_W-1:0]   frames_held_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic              primed_reg;

    logic [NB_W-1:0]    nb_eff;
    logic [NA_W-1:0]    na_eff;
    logic [BIN_W-1:0]   cur_bin;
    logic               cur_last;
    logic               avg_on;
    logic               filling;
    logic [SLOT_W-1:0]  cur_slot;
    logic [HIST_AW-1:0] cur_hist_addr;
    logic [1:0]         cur_sum_mode;
    logic               cur_div_on;
    logic               accept;

    assign nb_eff  = eff_bins(num_bins_reg);
    assign na_eff  = eff_avg(avg_frames_reg);

    // A counter left beyond the frame length starts over at bin zero.
    assign cur_bin  = ({1'b0, bin_cnt_reg} >= nb_eff) ? '0 : bin_cnt_reg;
    assign cur_last = ({1'b0, cur_bin} == (nb_eff - NB_W'(1)));

    assign avg_on   = (na_eff > NA_W'(1));
    assign filling  = (frames_held_reg < na_eff);

    // While the history fills, frame k goes to slot k; after that the oldest
    // slot is overwritten.
    assign cur_slot      = filling ? frames_held_reg[SLOT_W-1:0] : oldest_reg;
    assign cur_hist_addr = {cur_slot, cur_bin};

    always_comb
    begin
        if (frames_held_reg == '0)
            cur_sum_mode = SUM_FIRST;
        else if (filling)
            cur_sum_mode = SUM_ADD;
        else
            cur_sum_mode = SUM_SLIDE;
    end

    assign cur_div_on = avg_on &&
        (({1'b0, frames_held_reg} + (NA_W+1)'(1)) >= {1'b0, na_eff});

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg    <= NUM_BINS_RST;
            avg_frames_reg  <= AVG_FRAMES_RST;
            hold_en_reg     <= HOLD_RST;
            decay_reg       <= DECAY_RST;
            floor_reg       <= FLOOR_RST;
            bin_cnt_reg     <= '0;
            frames_held_reg <= '0;
            oldest_reg      <= '0;
            primed_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_BINS:
                begin
                    num_bins_reg <= cfg_data[NB_W-1:0];
                    // Only a change of the effective frame length restarts
                    // the frame, the peaks and the history.
                    if (eff_bins(cfg_data[NB_W-1:0]) != nb_eff)
                    begin
                        bin_cnt_reg     <= '0;
                        primed_reg      <= 1'b0;
                        frames_held_reg <= '0;
                        oldest_reg      <= '0;
                    end
                end
                REG_AVG_FRAMES:
                begin
                    avg_frames_reg  <= cfg_data[NA_W-1:0];
                    frames_held_reg <= '0;
                    oldest_reg      <= '0;
                end
                REG_HOLD_ENABLE: hold_en_reg <= cfg_data[0];
                REG_PEAK_DECAY:  decay_reg   <= cfg_data;
                REG_FLOOR_DB:    floor_reg   <= $signed(cfg_data);
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (cur_last)
            begin
                bin_cnt_reg <= '0;
                if (hold_en_reg)
                    primed_reg <= 1'b1;
                if (avg_on)
                begin
                    if (filling)
                        frames_held_reg <= frames_held_reg + NA_W'(1);
                    else if (({1'b0, oldest_reg} + NA_W'(1)) == na_eff)
                        oldest_reg <= '0;
                    else
                        oldest_reg <= oldest_reg + SLOT_W'(1);
                end
            end
            else
            begin
                bin_cnt_reg <= cur_bin + BIN_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or its word
    // moves on, so bubbles close up and the input keeps flowing while a
    // finished word waits at the output, until the stages behind it fill.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, out_valid_next;
    logic out_take, s3_take, s2_take, s1_take;
    logic s3_move, s2_move, s1_move;

    assign out_take = !out_valid_reg || out_ready;
    assign s3_move  = s3_valid_reg && out_take;
    assign s3_take  = !s3_valid_reg || out_take;
    assign s2_move  = s2_valid_reg && s3_take;
    assign s2_take  = !s2_valid_reg || s3_take;
    assign s1_move  = s1_valid_reg && s2_take;
    assign s1_take  = !s1_valid_reg || s2_take;
    assign in_ready = s1_take;

    assign s1_valid_next  = s1_take  ? accept       : s1_valid_reg;
    assign s2_valid_next  = s2_take  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_take  ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_take ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: memory read at acceptance, update and write-back one stage on
    // ------------------------------------------------------------------
    s1_t s1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.sample    <= bin_db;
            s1_reg.bin       <= cur_bin;
            s1_reg.hist_addr <= cur_hist_addr;
            s1_reg.hold_on   <= hold_en_reg;
            s1_reg.primed    <= primed_reg;
            s1_reg.avg_on    <= avg_on;
            s1_reg.sum_mode  <= cur_sum_mode;
            s1_reg.div_on    <= cur_div_on;
            s1_reg.na        <= na_eff;
            s1_reg.last      <= cur_last;
        end
    end

    // Per-bin word: running sum in the upper bits, held peak in the lower.
    logic [BIN_WORD_W-1:0] bin_mem [MAX_BINS];
    logic [BIN_WORD_W-1:0] bin_rd_reg;
    db_t                   hist_mem [HIST_DEPTH];
    db_t                   hist_rd_reg;

    logic [BIN_WORD_W-1:0] bin_wr_word;

    always_ff @(posedge clk)
    begin
        if (accept)
            bin_rd_reg <= bin_mem[cur_bin];
        if (s1_move)
            bin_mem[s1_reg.bin] <= bin_wr_word;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hist_rd_reg <= hist_mem[cur_hist_addr];
        if (s1_move && s1_reg.avg_on)
            hist_mem[s1_reg.hist_addr] <= s1_reg.sample;
    end

    // The most recent write to each memory. A word read in the same cycle
    // as that write saw the old contents, so a matching address takes the
    // value from here instead.
    logic                  fwd_bin_valid_reg;
    logic [BIN_W-1:0]      fwd_bin_addr_reg;
    logic [BIN_WORD_W-1:0] fwd_bin_word_reg;
    logic                  fwd_hist_valid_reg;
    logic [HIST_AW-1:0]    fwd_hist_addr_reg;
    db_t                   fwd_hist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_bin_valid_reg  <= 1'b0;
            fwd_hist_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            fwd_bin_valid_reg <= 1'b1;
            if (s1_reg.avg_on)
                fwd_hist_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            fwd_bin_addr_reg <= s1_reg.bin;
            fwd_bin_word_reg <= bin_wr_word;
            if (s1_reg.avg_on)
            begin
                fwd_hist_addr_reg <= s1_reg.hist_addr;
                fwd_hist_reg      <= s1_reg.sample;
            end
        end
    end

    logic [BIN_WORD_W-1:0] bin_word;
    db_t                   old_peak;
    sum_t                  old_sum;
    db_t                   old_hist;
    sum_t                  sample_wide;
    sum_t                  hist_wide;
    sum_t                  new_sum;
    sum_t                  wr_sum;
    db_t                   store_peak;
    db_t                   peak_out;
    peak_ctl_t             s1_peak_ctl;

    assign bin_word = (fwd_bin_valid_reg && (fwd_bin_addr_reg == s1_reg.bin)) ?
                      fwd_bin_word_reg : bin_rd_reg;
    assign old_hist = (fwd_hist_valid_reg && (fwd_hist_addr_reg == s1_reg.hist_addr)) ?
                      fwd_hist_reg : hist_rd_reg;

    assign old_peak = $signed(bin_word[DB_W-1:0]);
    assign old_sum  = $signed(bin_word[BIN_WORD_W-1:DB_W]);

    assign sample_wide = {{SLOT_W{s1_reg.sample[DB_W-1]}}, s1_reg.sample};
    assign hist_wide   = {{SLOT_W{old_hist[DB_W-1]}}, old_hist};

    always_comb
    begin
        case (s1_reg.sum_mode)
            SUM_FIRST: new_sum = sample_wide;
            SUM_ADD:   new_sum = old_sum + sample_wide;
            SUM_SLIDE: new_sum = old_sum - hist_wide + sample_wide;
            default:   new_sum = sample_wide;
        endcase
    end

    // With averaging off the stored sum is left as it was.
    assign wr_sum = s1_reg.avg_on ? new_sum : old_sum;

    assign s1_peak_ctl.hold_on = s1_reg.hold_on;
    assign s1_peak_ctl.primed  = s1_reg.primed;

    spha_peak_calc u_peak_calc (
        .ctl        (s1_peak_ctl),
        .old_peak   (old_peak),
        .sample     (s1_reg.sample),
        .floor_lvl  (floor_reg),
        .decay      (decay_reg),
        .store_peak (store_peak),
        .peak_out   (peak_out)
    );

    assign bin_wr_word = {wr_sum, store_peak};

    // ------------------------------------------------------------------
    // Stage 2: magnitude of the sum times the reciprocal of the depth
    // ------------------------------------------------------------------
    s2_t s2_reg;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_reg.sum     <= new_sum;
            s2_reg.sample  <= s1_reg.sample;
            s2_reg.peak    <= peak_out;
            s2_reg.hold_on <= s1_reg.hold_on;
            s2_reg.div_on  <= s1_reg.div_on;
            s2_reg.na      <= s1_reg.na;
            s2_reg.last    <= s1_reg.last;
        end
    end

    logic               sum_neg;
    logic [SUM_W-1:0]   sum_mag;
    logic [QPROD_W-1:0] quot_prod;

    assign sum_neg   = s2_reg.sum[SUM_W-1];
    assign sum_mag   = sum_neg ? SUM_W'(-s2_reg.sum) : SUM_W'(s2_reg.sum);
    assign quot_prod = sum_mag * recip(s2_reg.na);

    // ------------------------------------------------------------------
    // Stage 3: quotient, sign restored (truncation toward zero)
    // ------------------------------------------------------------------
    s3_t s3_reg;

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_reg.prod    <= quot_prod;
            s3_reg.neg     <= sum_neg;
            s3_reg.sample  <= s2_reg.sample;
            s3_reg.peak    <= s2_reg.peak;
            s3_reg.hold_on <= s2_reg.hold_on;
            s3_reg.div_on  <= s2_reg.div_on;
            s3_reg.last    <= s2_reg.last;
        end
    end

    logic [SUM_W-1:0] quot;
    logic [SUM_W-1:0] quot_signed;
    db_t              disp_val;

    assign quot        = s3_reg.prod[QPROD_W-1:RECIP_W];
    assign quot_signed = s3_reg.neg ? (~quot + SUM_W'(1)) : quot;
    assign disp_val    = s3_reg.div_on ? $signed(quot_signed[DB_W-1:0]) : s3_reg.sample;

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    db_t  display_reg;
    db_t  peak_reg;
    logic peak_valid_reg;
    logic frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            display_reg    <= disp_val;
            peak_reg       <= s3_reg.peak;
            peak_valid_reg <= s3_reg.hold_on;
            frame_end_reg  <= s3_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign display_db = display_reg;
    assign peak_db    = peak_reg;
    assign peak_valid = peak_valid_reg;
    assign frame_end  = frame_end_reg;

endmodule

[design/spha_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// spha_checker
// Port-level checks for the spectrum peak-hold and frame-averaging block.
// ============================================================================

module spha_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input spha_pkg::db_t                      bin_db,
    input logic                               out_valid,
    input logic                               out_ready,
    input spha_pkg::db_t                      display_db,
    input spha_pkg::db_t                      peak_db,
    input logic                               peak_valid,
    input logic                               frame_end,
    input logic                               cfg_write,
    input logic [spha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [spha_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spha_pkg::*;

    // A stalled result word stays valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(display_db) && $stable(peak_db) &&
                                    $stable(peak_valid) && $stable(frame_end))
        else $error("output word changed while stalled");

    // When the output register is free or being emptied, every stage can
    // move, so the input must be open.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked with a free output register");

    // With peak hold off the peak field reads zero.
    a_peak_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !peak_valid |-> peak_db == '0)
        else $error("peak level nonzero with peak hold off");

endmodule

bind spectrum_peak_hold_averager spha_checker u_spha_checker (.*);

[test/spha_bin_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// spha_bin_checker
// Watches the bin, result and register ports of the spectrum averager. It
// keeps its own copy of the per-bin peaks, sums and history, predicts every
// output word and compares it with what comes out.
// ============================================================================

module spha_bin_checker (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_ready,
    input  spha_pkg::db_t                   bin_db,

    input  logic                            out_valid,
    input  logic                            out_ready,
    input  spha_pkg::db_t                   display_db,
    input  spha_pkg::db_t                   peak_db,
    input  logic                            peak_valid,
    input  logic                            frame_end,

    input  logic                            cfg_write,
    input  logic [spha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spha_pkg::CFG_DATA_W-1:0] cfg_data,

    output int                              error_count,
    output int                              words_pending
);

    import spha_pkg::*;

    typedef struct packed {
        db_t  display;
        db_t  peak;
        logic peak_on;
        logic last;
    } bin_word_t;

    bin_word_t expected_bins [$];

    // Per-bin state, indexed like the block's memories.
    db_t hold_peak [MAX_BINS];
    db_t hist_bins [HIST_DEPTH];
    int  bin_sum   [MAX_BINS];

    int   frames_seen;
    int   oldest_slot;
    int   bin_idx;
    logic peaks_ready;
    int   errors = 0;

    // Register copies.
    logic [12:0] r_bins;
    logic [4:0]  r_avg;
    logic        r_hold;
    logic [15:0] r_decay;
    db_t         r_floor;

    function automatic int bins_in_use(input logic [12:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_BINS)
            return MAX_BINS;
        return int'(r);
    endfunction

    function automatic int frames_in_use(input logic [4:0] r);
        if (r == '0)
            return 1;
        if (int'(r) > MAX_AVG_FRAMES)
            return MAX_AVG_FRAMES;
        return int'(r);
    endfunction

    // Advances the per-bin state by one bin and returns the word it produces.
    function automatic bin_word_t average_and_hold(input db_t x);
        int        nb;
        int        na;
        int        b;
        int        pk;
        int        disp;
        int        sum;
        int        slot;
        int        idx;
        longint    mix;
        bin_word_t w;
        nb   = bins_in_use(r_bins);
        na   = frames_in_use(r_avg);
        b    = (bin_idx >= nb) ? 0 : bin_idx;
        pk   = 0;
        disp = int'(x);

        if (r_hold) begin
            if (!peaks_ready) begin
                pk = int'(x);
            end
            else begin
                // Pull the old peak toward the floor, rounding toward minus infinity.
                mix = longint'(hold_peak[b]) * longint'(r_decay)
                    + longint'(r_floor) * (longint'(65536) - longint'(r_decay));
                pk = int'(mix >>> 16);
                if (int'(x) > pk)
                    pk = int'(x);
            end
            hold_peak[b] = db_t'(pk);
        end

        if (na > 1) begin
            slot = (frames_seen < na) ? frames_seen : oldest_slot;
            idx  = (slot % MAX_AVG_FRAMES) * MAX_BINS + b;
            if (frames_seen == 0)
                sum = int'(x);
            else if (frames_seen < na)
                sum = bin_sum[b] + int'(x);
            else
                sum = bin_sum[b] - int'(hist_bins[idx]) + int'(x);
            bin_sum[b]     = sum;
            hist_bins[idx] = x;
            if (frames_seen + 1 >= na)
                disp = sum / na;
        end

        w.last = (b == nb - 1);
        if (w.last) begin
            if (r_hold)
                peaks_ready = 1'b1;
            if (na > 1) begin
                if (frames_seen < na)
                    frames_seen++;
                else
                    oldest_slot = (oldest_slot + 1) % na;
            end
            bin_idx = 0;
        end
        else begin
            bin_idx = b + 1;
        end

        w.display = db_t'(disp);
        w.peak    = db_t'(pk);
        w.peak_on = r_hold;
        return w;
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_NUM_BINS:
            begin
                if (bins_in_use(data[12:0]) != bins_in_use(r_bins)) begin
                    bin_idx     = 0;
                    peaks_ready = 1'b0;
                    frames_seen = 0;
                    oldest_slot = 0;
                end
                r_bins = data[12:0];
            end
            REG_AVG_FRAMES:
            begin
                r_avg       = data[4:0];
                frames_seen = 0;
                oldest_slot = 0;
            end
            REG_HOLD_ENABLE: r_hold  = data[0];
            REG_PEAK_DECAY:  r_decay = data;
            REG_FLOOR_DB:    r_floor = db_t'(data);
            default:         ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bin_word_t want;
        if (!rst_n) begin
            expected_bins.delete();
            frames_seen   = 0;
            oldest_slot   = 0;
            bin_idx       = 0;
            peaks_ready   = 1'b0;
            r_bins        = NUM_BINS_RST;
            r_avg         = AVG_FRAMES_RST;
            r_hold        = HOLD_RST;
            r_decay       = DECAY_RST;
            r_floor       = FLOOR_RST;
            words_pending <= 0;
            error_count   <= errors;
        end
        else begin
            if (cfg_write)
                apply_register(cfg_index, cfg_data);

            // The oldest prediction is retired before a new one is queued.
            if (out_valid && out_ready) begin
                if (expected_bins.size() == 0) begin
                    $error("output word arrived with no word expected");
                    errors++;
                end
                else begin
                    want = expected_bins.pop_front();
                    if (display_db !== want.display) begin
                        $error("display_db: expected %0d, got %0d", want.display, display_db);
                        errors++;
                    end
                    if (peak_db !== want.peak) begin
                        $error("peak_db: expected %0d, got %0d", want.peak, peak_db);
                        errors++;
                    end
                    if (peak_valid !== want.peak_on) begin
                        $error("peak_valid: expected %0b, got %0b", want.peak_on, peak_valid);
                        errors++;
                    end
                    if (frame_end !== want.last) begin
                        $error("frame_end: expected %0b, got %0b", want.last, frame_end);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
                expected_bins.push_back(average_and_hold(bin_db));

            words_pending <= expected_bins.size();
            error_count   <= errors;
        end
    end

endmodule

[test/spectrum_peak_hold_averager_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// spectrum_peak_hold_averager_tb
// Drives spectrum frames into the peak-hold averager under changing register
// settings and idle patterns; a separate checker predicts and compares every
// output word, and this module reports the verdict.
// ============================================================================

module spectrum_peak_hold_averager_tb;

    import spha_pkg::*;

    // Total bins to offer before the run winds down.
    localparam int RUN_WORDS  = 1650;
    // Length of a forced receiver hold-off, in cycles.
    localparam int LONG_STALL = 300;
    // Longest run of idle cycles the sender inserts before one word.
    localparam int MAX_GAP    = 20;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  in_valid;
    logic                  in_ready;
    db_t                   bin_db;

    logic                  out_valid;
    logic                  out_ready;
    db_t                   display_db;
    db_t                   peak_db;
    logic                  peak_valid;
    logic                  frame_end;

    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int words_pending;

    // Idle percentages for the two sides. The sender's is read only by the
    // stimulus process; the receiver's is handed over with nonblocking writes.
    int send_idle_pct;
    int recv_stall_pct;

    // A long receiver hold-off is requested by bumping stall_requests; the
    // receiver process serves each request once and counts the stall itself.
    int stall_requests;
    int stall_served;
    int stall_left;

    int words_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spectrum_peak_hold_averager u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .bin_db     (bin_db),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .display_db (display_db),
        .peak_db    (peak_db),
        .peak_valid (peak_valid),
        .frame_end  (frame_end),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    spha_bin_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .bin_db        (bin_db),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .display_db    (display_db),
        .peak_db       (peak_db),
        .peak_valid    (peak_valid),
        .frame_end     (frame_end),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .words_pending (words_pending)
    );

    // Safety net: the slowest legal run finishes well inside this window.
    initial
    begin : watchdog
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    // Receiver side. Each cycle it either serves a long hold-off or stalls at
    // random according to the current idle mode.
    initial
    begin : receiver
        out_ready    = 1'b0;
        stall_served = 0;
        stall_left   = 0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (stall_served != stall_requests) begin
                stall_served++;
                stall_left = LONG_STALL - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 52;
                recv_stall_pct <= 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 52;
            end
            default:
            begin
                send_idle_pct = 19;
                recv_stall_pct <= 19;
            end
        endcase
    endtask

    // Offers one bin and returns at the edge where it is taken. Valid stays
    // high on return, so back-to-back words keep it up without a glitch; a
    // gap lowers it first and raises it again with the new payload.
    task automatic push_bin(input db_t level);
        int gaps;
        gaps = 0;
        while (gaps < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gaps++;
        if (gaps > 0) begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid <= 1'b1;
        bin_db   <= level;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Stops offering words and waits until every predicted word has come
    // out. The checker's count is registered, so the first look is taken in the
    // cycle after the last acceptance.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    // One register write; the write strobe is lowered again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Bin levels: mostly a noise-like band from -1600 to 200, above the default
    // floor, with some full-range words and some rail values mixed in.
    function automatic db_t pick_level();
        db_t v;
        case ($urandom_range(0, 7))
            0:       v = db_t'($urandom_range(0, 65535));
            1:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: v = db_t'(200 - int'($urandom_range(0, 1800)));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_decay();
        logic [15:0] d;
        case ($urandom_range(0, 4))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            2:       d = DECAY_RST;
            default: d = 16'($urandom_range(0, 65535));
        endcase
        return d;
    endfunction

    function automatic logic [15:0] pick_floor();
        logic [15:0] f;
        case ($urandom_range(0, 4))
            0:       f = 16'h8000;
            1:       f = 16'h7FFF;
            2:       f = 16'($urandom_range(0, 65535));
            default: f = 16'(-int'($urandom_range(0, 3000)));
        endcase
        return f;
    endfunction

    // One random phase: new settings, then whole frames only, so that every
    // phase starts on a frame boundary. Peak hold and the averaging depth are
    // therefore only ever changed between frames here, which keeps the block
    // from reading peak or history entries that were never written. The
    // frame count covers the averaging depth with a few frames to spare, so
    // the sliding window gets exercised; the bin count is kept small to fit.
    task automatic random_phase(input idle_mode_t mode);
        int avg_raw;
        int avg_eff;
        int frames;
        int bins_raw;
        int bins_eff;
        avg_raw  = $urandom_range(0, 31);
        avg_eff  = (avg_raw == 0) ? 1 : ((avg_raw > MAX_AVG_FRAMES) ? MAX_AVG_FRAMES : avg_raw);
        frames   = avg_eff + 1 + $urandom_range(0, 3);
        bins_raw = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 180 / frames);
        bins_eff = (bins_raw == 0) ? 1 : bins_raw;

        write_reg(REG_NUM_BINS, 16'(bins_raw));
        // Leaving the depth alone now and then lets history run on across phases.
        if ($urandom_range(0, 3) != 0)
            write_reg(REG_AVG_FRAMES, 16'(avg_raw));
        if ($urandom_range(0, 1) != 0)
            write_reg(REG_HOLD_ENABLE, 16'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) != 0)
            write_reg(REG_PEAK_DECAY, pick_decay());
        if ($urandom_range(0, 1) != 0)
            write_reg(REG_FLOOR_DB, pick_floor());

        set_idling(mode);
        repeat (frames * bins_eff)
            push_bin(pick_level());
        drain();
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        bin_db         = '0;
        cfg_write      = 1'b0;
        cfg_index      = REG_NUM_BINS;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_requests = 0;
        words_sent     = 0;
        phase          = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------------------------------------------------------
        // Directed part on four-bin frames, averaging over two frames.
        // ---------------------------------------------------------------
        set_idling(IDLE_BOTH);
        write_reg(REG_NUM_BINS, 16'd4);
        write_reg(REG_AVG_FRAMES, 16'd2);
        write_reg(REG_HOLD_ENABLE, 16'd1);
        write_reg(REG_PEAK_DECAY, 16'hFFFF);
        write_reg(REG_FLOOR_DB, 16'h8000);

        // First frame after the bin-count change: peaks copy the input and the
        // display is raw. Both rails and the values next to zero go in.
        push_bin(16'sh7FFF);
        push_bin(16'sh8000);
        push_bin(16'sd0);
        push_bin(-16'sd1);
        // Second frame: full averages at the rails, and -1 over two frames
        // must truncate toward zero. The peak decays with the largest factor.
        push_bin(16'sh7FFF);
        push_bin(16'sh8000);
        push_bin(-16'sd1);
        push_bin(16'sd1);
        drain();

        // A decay factor of zero and a floor at the top rail: every peak snaps up.
        write_reg(REG_PEAK_DECAY, 16'h0000);
        write_reg(REG_FLOOR_DB, 16'h7FFF);
        push_bin(-16'sd5);
        push_bin(16'sd100);
        push_bin(16'sh7FFF);
        push_bin(16'sh8000);
        drain();

        // Floor at the bottom rail: peaks fall straight to it, then take the input.
        write_reg(REG_FLOOR_DB, 16'h8000);
        push_bin(16'sh5555);
        push_bin(16'shAAAA);
        push_bin(16'sd1);
        push_bin(-16'sd2);

        // Peak hold switched off part-way through a frame, then back on
        // part-way through the next. The peaks are primed by now and every
        // entry of this bin count has been written, so both switches are safe.
        push_bin(16'sh7FF0);
        push_bin(-16'sd16);
        drain();
        write_reg(REG_HOLD_ENABLE, 16'd0);
        push_bin(16'sd7);
        push_bin(16'sd8);
        push_bin(16'sd9);
        push_bin(16'sd10);
        drain();
        write_reg(REG_HOLD_ENABLE, 16'd1);
        push_bin(16'sd11);
        push_bin(-16'sd12);

        // Averaging restart in the middle of a frame: the first two bins keep
        // their old running sums, which the depth of two has fully written.
        push_bin(16'sd300);
        push_bin(-16'sd300);
        drain();
        write_reg(REG_AVG_FRAMES, 16'd2);
        push_bin(16'sd5);
        push_bin(-16'sd5);
        drain();

        // ---------------------------------------------------------------
        // Largest frame size, partly filled. Rewrites of the bin count that
        // clamp to the same size must leave the bin position alone. The
        // receiver is held off twice while words keep coming, so the block
        // fills up and has to stall its input.
        // ---------------------------------------------------------------
        set_idling(IDLE_RECEIVER);
        write_reg(REG_NUM_BINS, 16'd4096);
        write_reg(REG_AVG_FRAMES, 16'd16);
        stall_requests <= stall_requests + 1;
        repeat (60)
            push_bin(pick_level());
        drain();
        write_reg(REG_NUM_BINS, 16'd5000);
        repeat (40)
            push_bin(pick_level());
        drain();
        write_reg(REG_NUM_BINS, 16'd8191);
        write_reg(REG_AVG_FRAMES, 16'd31);
        stall_requests <= stall_requests + 1;
        repeat (40)
            push_bin(pick_level());
        drain();

        // ---------------------------------------------------------------
        // Random phases, cycling through the idle patterns. Each one ends
        // with the sender paused until the block has emptied.
        // ---------------------------------------------------------------
        while (words_sent < RUN_WORDS) begin
            random_phase(idle_mode_t'(phase % 4));
            phase++;
        end

        // Everything has drained; give the block further time to show any stray
        // word before the verdict.
        repeat (20) @(posedge clk);
        if (error_count == 0 && words_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
